>>> src/b64sc_pkg.sv
// Shared types, constants and alphabet functions for the Base64 stream codec.
// No dependencies; imported by every module under src.
package b64sc_pkg;

    localparam int MaxResults = 4;
    localparam int ResIdxW    = $clog2(MaxResults);

    localparam logic [7:0] PadChar     = 8'h3D;
    localparam logic [6:0] CodePad     = 7'd64;
    localparam logic [6:0] CodeUnknown = 7'd65;

    localparam logic MODE_ENCODE = 1'b0;
    localparam logic MODE_DECODE = 1'b1;

    localparam logic REG_MODE = 1'b0;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       in_last;
    } b64_in_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       has_byte;
        logic       out_last;
        logic       error;
    } b64_out_t;

    // One accepted item's worth of results, queued between front and back.
    typedef struct packed {
        logic [MaxResults-1:0][7:0] bytes;
        logic [ResIdxW-1:0]         last_idx;
        logic                       has_byte;
        logic                       msg_last;
        logic                       error;
    } b64_job_t;

    function automatic logic [11:0] mask12(input logic [3:0] n);
        logic [12:0] one;
        one = 13'd1 << n;
        return 12'(one - 13'd1);
    endfunction

    function automatic logic [7:0] enc_char(input logic [5:0] idx);
        logic [7:0] i8;
        i8 = {2'b00, idx};
        if (idx < 6'd26)      return 8'h41 + i8;
        else if (idx < 6'd52) return 8'h61 + i8 - 8'd26;
        else if (idx < 6'd62) return 8'h30 + i8 - 8'd52;
        else if (idx == 6'd62) return 8'h2B;
        else                   return 8'h2F;
    endfunction

    function automatic logic [6:0] char_value(input logic [7:0] c);
        if (c >= 8'h41 && c <= 8'h5A)      return 7'(c - 8'h41);
        else if (c >= 8'h61 && c <= 8'h7A) return 7'(c - 8'h61 + 8'd26);
        else if (c >= 8'h30 && c <= 8'h39) return 7'(c - 8'h30 + 8'd52);
        else if (c == 8'h2B)               return 7'd62;
        else if (c == 8'h2F)               return 7'd63;
        else if (c == PadChar)             return CodePad;
        else                               return CodeUnknown;
    endfunction

endpackage

>>> src/b64sc_front.sv
// Front end: accepts input transfers, runs the encode/decode bit packing and
// builds a result job for each transfer that yields a result. Depends on b64sc_pkg.
module b64sc_front import b64sc_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     mode,
    input  logic     cfg_clear,
    input  logic     s_valid,
    output logic     s_ready,
    input  b64_in_t  s_data,
    output logic     job_valid,
    input  logic     job_ready,
    output b64_job_t job
);

    logic [7:0] bit_residue_reg, bit_residue_next;
    logic [3:0] residue_count_reg, residue_count_next;
    logic [1:0] group_position_reg, group_position_next;
    logic       quad_padded_reg, quad_padded_next;
    logic       quad_produced_reg, quad_produced_next;
    logic       error_seen_reg, error_seen_next;

    logic        accept;
    logic        produce;
    logic [11:0] res_masked;

    // encode path
    logic [11:0] eacc;
    logic [3:0]  etot;
    logic        etwo;
    logic [3:0]  erem;
    logic [11:0] eacc_rem;
    logic [11:0] etail;

    // decode path
    logic [6:0]  dval;
    logic [11:0] dacc;
    logic [3:0]  dtot;
    logic [3:0]  dcnt;

    assign s_ready = job_ready;
    assign accept  = s_valid && job_ready;
    assign job_valid = accept && produce;
    assign res_masked = {4'b0000, bit_residue_reg} & mask12(residue_count_reg);

    always_comb begin
        bit_residue_next    = bit_residue_reg;
        residue_count_next  = residue_count_reg;
        group_position_next = group_position_reg;
        quad_padded_next    = quad_padded_reg;
        quad_produced_next  = quad_produced_reg;
        error_seen_next     = error_seen_reg;
        job      = '0;
        produce  = 1'b0;

        eacc     = {res_masked[3:0], s_data.in_byte};
        etot     = residue_count_reg + 4'd8;
        etwo     = (etot >= 4'd12);
        erem     = etwo ? 4'd0 : etot - 4'd6;
        eacc_rem = eacc & mask12(erem);
        etail    = eacc_rem << (4'd6 - erem);

        dval  = char_value(s_data.in_byte);
        dacc  = {res_masked[5:0], dval[5:0]};
        dtot  = residue_count_reg + 4'd6;
        dcnt  = dtot;

        if (mode == MODE_ENCODE) begin
            produce = 1'b1;
            job.has_byte = 1'b1;
            job.msg_last = s_data.in_last;
            job.bytes[0] = enc_char(6'(eacc >> (etot - 4'd6)));
            if (etwo) begin
                job.bytes[1] = enc_char(eacc[5:0]);
                job.last_idx = 2'd1;
            end else if (s_data.in_last) begin
                job.bytes[1] = enc_char(etail[5:0]);
                job.bytes[2] = PadChar;
                if (erem <= 4'd2) begin
                    job.bytes[3] = PadChar;
                    job.last_idx = 2'd3;
                end else begin
                    job.last_idx = 2'd2;
                end
            end else begin
                job.last_idx = 2'd0;
            end
            bit_residue_next   = eacc_rem[7:0];
            residue_count_next = erem;
        end else begin
            if (!quad_padded_reg) begin
                if (dval == CodeUnknown) begin
                    error_seen_next = 1'b1;
                end else if (dval == CodePad) begin
                    quad_padded_next = 1'b1;
                end else begin
                    if (dtot >= 4'd8) begin
                        dcnt = dtot - 4'd8;
                        job.bytes[0] = 8'(dacc >> dcnt);
                        job.has_byte = 1'b1;
                        produce = 1'b1;
                        quad_produced_next = 1'b1;
                    end
                    bit_residue_next   = 8'(dacc & mask12(dcnt));
                    residue_count_next = dcnt;
                end
            end
            group_position_next = group_position_reg + 2'd1;
            if (group_position_next == 2'd0) begin
                if (!quad_produced_next) error_seen_next = 1'b1;
                bit_residue_next   = '0;
                residue_count_next = '0;
                quad_padded_next   = 1'b0;
                quad_produced_next = 1'b0;
            end
            if (s_data.in_last) begin
                if (group_position_next != 2'd0 && !quad_produced_next) begin
                    error_seen_next = 1'b1;
                end
                produce = 1'b1;
                job.msg_last = 1'b1;
                job.error = error_seen_next;
            end
            job.last_idx = 2'd0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || cfg_clear || (accept && s_data.in_last)) begin
            bit_residue_reg    <= '0;
            residue_count_reg  <= '0;
            group_position_reg <= '0;
            quad_padded_reg    <= 1'b0;
            quad_produced_reg  <= 1'b0;
            error_seen_reg     <= 1'b0;
        end else if (accept) begin
            bit_residue_reg    <= bit_residue_next;
            residue_count_reg  <= residue_count_next;
            group_position_reg <= group_position_next;
            quad_padded_reg    <= quad_padded_next;
            quad_produced_reg  <= quad_produced_next;
            error_seen_reg     <= error_seen_next;
        end
    end

endmodule

>>> src/b64sc_queue.sv
// Two-entry job queue decoupling the front end from the result serialiser.
// Depends on b64sc_pkg.
module b64sc_queue import b64sc_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     push,
    input  b64_job_t push_job,
    output logic     not_full,
    output logic     not_empty,
    input  logic     pop,
    output b64_job_t head
);

    b64_job_t   mem [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;

    assign not_full  = (count_reg != 2'd2);
    assign not_empty = (count_reg != 2'd0);
    assign head      = mem[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop  ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (push) mem[wr_ptr_reg] <= push_job;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

>>> src/b64sc_back.sv
// Back end: serialises the head job into one result transfer per cycle while
// m_ready allows, through an output register. Depends on b64sc_pkg.
module b64sc_back import b64sc_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     head_valid,
    input  b64_job_t head,
    output logic     pop,
    output logic     m_valid,
    input  logic     m_ready,
    output b64_out_t m_data
);

    logic [ResIdxW-1:0] idx_reg, idx_next;
    logic               m_valid_reg, m_valid_next;
    b64_out_t           m_data_reg, m_data_next;
    logic               load;
    logic               is_final;

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    always_comb begin
        load     = head_valid && (!m_valid_reg || m_ready);
        is_final = (idx_reg == head.last_idx);
        pop      = load && is_final;
        idx_next = pop ? '0 : (load ? idx_reg + 1'b1 : idx_reg);

        m_valid_next = load ? 1'b1 : (m_ready ? 1'b0 : m_valid_reg);
        m_data_next  = m_data_reg;
        if (load) begin
            m_data_next.out_byte = head.has_byte ? head.bytes[idx_reg] : 8'd0;
            m_data_next.has_byte = head.has_byte;
            m_data_next.out_last = is_final && head.msg_last;
            m_data_next.error    = is_final && head.msg_last && head.error;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            idx_reg     <= idx_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
    end

    a_status_only_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && !m_data_reg.has_byte |-> m_data_reg.out_last)
        else $error("status-only transfer without out_last");

    a_error_only_on_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_data_reg.error |-> m_data_reg.out_last)
        else $error("error flag on a non-final transfer");

    a_idx_within_job: assert property (@(posedge aclk) disable iff (!aresetn)
        head_valid |-> idx_reg <= head.last_idx)
        else $error("result index past end of job");

    a_idx_clears_on_pop: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |=> idx_reg == '0)
        else $error("result index not cleared after job");

endmodule

>>> src/base64_stream_codec.sv
// Base64 stream codec top level: APB mode register, front end, job queue
// and result serialiser. Depends on b64sc_pkg and the b64sc_* modules.
//
// Usage:
//   Input channel s_valid/s_ready/s_data carries one byte (encode) or one
//   character (decode) per transfer, with in_last marking the message end.
//   Output channel m_valid/m_ready/m_data carries characters or decoded
//   bytes; out_last marks the final transfer of a message and error on that
//   transfer flags invalid decode input. A decode character that yields no
//   byte produces no transfer, except on in_last where a status-only
//   transfer (has_byte low) is sent.
//   The mode register (address 0, bit 0) selects encode (0) or decode (1);
//   writing it clears the front end's message state. Write only while idle.
// Results: an accepted job is written into the job queue, then loaded into
//   the output register, which drives m_valid.
// Throughput: one input per cycle when each yields one result, m_ready high;
//   the serialiser sends one result per cycle unless stalled, so an item with
//   several results (up to four on the final encode byte) holds it until done.
// Reset: aresetn low clears mode to encode and empties all state.
// Stall: with m_ready low the output register holds; the two-entry job
//   queue fills and then s_ready drops.
module base64_stream_codec import b64sc_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        s_valid,
    output logic        s_ready,
    input  b64_in_t     s_data,
    output logic        m_valid,
    input  logic        m_ready,
    output b64_out_t    m_data
);

    logic     mode_reg, mode_next;
    logic     cfg_clear;
    logic     job_valid;
    logic     q_not_full;
    logic     q_not_empty;
    logic     q_pop;
    b64_job_t job;
    b64_job_t head;

    assign pready    = 1'b1;
    assign prdata    = {31'd0, mode_reg};
    assign cfg_clear = psel && penable && pwrite && (paddr[2] == REG_MODE);
    assign mode_next = cfg_clear ? pwdata[0] : mode_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= MODE_ENCODE;
        end else begin
            mode_reg <= mode_next;
        end
    end

    b64sc_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .mode      (mode_reg),
        .cfg_clear (cfg_clear),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .job_valid (job_valid),
        .job_ready (q_not_full),
        .job       (job)
    );

    b64sc_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (job_valid),
        .push_job  (job),
        .not_full  (q_not_full),
        .not_empty (q_not_empty),
        .pop       (q_pop),
        .head      (head)
    );

    b64sc_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head_valid (q_not_empty),
        .head       (head),
        .pop        (q_pop),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data)
    );

endmodule

>>> verif/tb.sv
// Self-checking testbench for base64_stream_codec: directed and random encode and decode
// messages, with randomised source gaps and sink stalls, and a scoreboard that predicts
// every output transfer. Depends on b64sc_pkg and the RTL under src.
module tb;
    import b64sc_pkg::*;

    localparam int         QuietLimit   = 2000;
    localparam int         SettleCycles = 6;
    localparam int         MaxGap       = 24;
    localparam int         PressureHold = 90;
    localparam int         PhaseItems   = 25;
    localparam logic [2:0] ModeAddr     = 3'(4 * REG_MODE);
    localparam logic [2:0] SpareAddr    = 3'd4;

    class codec_scoreboard;
        string      alphabet = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
        b64_out_t   expected_symbols[$];
        int         errors;
        logic       mode;
        logic [7:0] residue;
        logic [3:0] residue_bits;
        logic [1:0] quad_pos;
        logic       quad_padded;
        logic       quad_produced;
        logic       bad_input;

        function new();
            errors = 0;
            mode   = MODE_ENCODE;
            clear_message();
        endfunction

        function void clear_message();
            residue       = '0;
            residue_bits  = '0;
            quad_pos      = '0;
            quad_padded   = 1'b0;
            quad_produced = 1'b0;
            bad_input     = 1'b0;
        endfunction

        function void set_mode(logic m);
            mode = m;
            clear_message();
        endfunction

        function int pending();
            return expected_symbols.size();
        endfunction

        function b64_out_t symbol(logic [7:0] value, logic has);
            b64_out_t s;
            s.out_byte = value;
            s.has_byte = has;
            s.out_last = 1'b0;
            s.error    = 1'b0;
            return s;
        endfunction

        function logic [6:0] sextet(logic [7:0] c);
            for (int i = 0; i < 64; i++) begin
                if (alphabet[i] == c)
                    return 7'(i);
            end
            if (c == PadChar)
                return CodePad;
            return CodeUnknown;
        endfunction

        function void encode_byte(b64_in_t item);
            b64_out_t    res[4];
            logic [15:0] acc;
            int          bits;
            int          n;
            n    = 0;
            bits = int'(residue_bits) & 7;
            acc  = (({8'h00, residue} & ((16'd1 << bits) - 16'd1)) << 8) | {8'h00, item.in_byte};
            bits += 8;
            while (bits >= 6) begin
                bits -= 6;
                res[n] = symbol(alphabet[int'((acc >> bits) & 16'h3F)], 1'b1);
                n++;
            end
            acc &= (16'd1 << bits) - 16'd1;
            if (item.in_last) begin
                if (bits > 0) begin
                    res[n] = symbol(alphabet[int'((acc << (6 - bits)) & 16'h3F)], 1'b1);
                    res[n + 1] = symbol(PadChar, 1'b1);
                    n += 2;
                    if (bits <= 2) begin
                        res[n] = symbol(PadChar, 1'b1);
                        n++;
                    end
                end
                res[n - 1].out_last = 1'b1;
                clear_message();
            end else begin
                residue      = acc[7:0];
                residue_bits = 4'(bits);
            end
            for (int i = 0; i < n; i++)
                expected_symbols.push_back(res[i]);
        endfunction

        function void decode_char(b64_in_t item);
            b64_out_t    res;
            logic [15:0] acc;
            logic [6:0]  v;
            int          bits;
            logic        emit;
            emit = 1'b0;
            res  = symbol(8'h00, 1'b0);
            if (!quad_padded) begin
                v = sextet(item.in_byte);
                if (v == CodeUnknown) begin
                    bad_input = 1'b1;
                end else if (v == CodePad) begin
                    quad_padded = 1'b1;
                end else begin
                    bits = int'(residue_bits) & 7;
                    acc  = (({8'h00, residue} & ((16'd1 << bits) - 16'd1)) << 6) | {9'h000, v};
                    bits += 6;
                    if (bits >= 8) begin
                        bits -= 8;
                        res           = symbol(8'((acc >> bits) & 16'hFF), 1'b1);
                        emit          = 1'b1;
                        quad_produced = 1'b1;
                    end
                    residue      = 8'(acc & ((16'd1 << bits) - 16'd1));
                    residue_bits = 4'(bits);
                end
            end
            quad_pos = quad_pos + 2'd1;
            if (quad_pos == 2'd0) begin
                if (!quad_produced)
                    bad_input = 1'b1;
                residue       = '0;
                residue_bits  = '0;
                quad_padded   = 1'b0;
                quad_produced = 1'b0;
            end
            if (item.in_last) begin
                if (quad_pos != 2'd0 && !quad_produced)
                    bad_input = 1'b1;
                res.out_last = 1'b1;
                res.error    = bad_input;
                emit         = 1'b1;
                clear_message();
            end
            if (emit)
                expected_symbols.push_back(res);
        endfunction

        function void take_input(b64_in_t item);
            if (mode == MODE_ENCODE)
                encode_byte(item);
            else
                decode_char(item);
        endfunction

        function void check_result(b64_out_t got);
            b64_out_t want;
            if (expected_symbols.size() == 0) begin
                $error("unexpected transfer: out_byte %02h has_byte %0b out_last %0b error %0b",
                       got.out_byte, got.has_byte, got.out_last, got.error);
                errors++;
                return;
            end
            want = expected_symbols.pop_front();
            if (got.out_byte !== want.out_byte) begin
                $error("out_byte: expected %02h, got %02h", want.out_byte, got.out_byte);
                errors++;
            end
            if (got.has_byte !== want.has_byte) begin
                $error("has_byte: expected %0b, got %0b", want.has_byte, got.has_byte);
                errors++;
            end
            if (got.out_last !== want.out_last) begin
                $error("out_last: expected %0b, got %0b", want.out_last, got.out_last);
                errors++;
            end
            if (got.error !== want.error) begin
                $error("error: expected %0b, got %0b", want.error, got.error);
                errors++;
            end
        endfunction
    endclass

    logic        aclk    = 1'b0;
    logic        aresetn = 1'b0;
    logic        psel    = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite  = 1'b0;
    logic [2:0]  paddr   = '0;
    logic [31:0] pwdata  = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        s_valid = 1'b0;
    logic        s_ready;
    b64_in_t     s_data  = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    b64_out_t    m_data;

    codec_scoreboard sb = new();
    logic [7:0]      msg_bytes[$];
    int              idle_pct       = 0;
    int              stall_pct      = 0;
    int              items_sent     = 0;
    int              quiet_cycles   = 0;
    int              hold_left      = 0;
    logic            pressure_req   = 1'b0;
    logic            pressure_taken = 1'b0;
    int              idle_plan[4]   = '{0, 58, 0, 34};
    int              stall_plan[4]  = '{0, 0, 58, 34};

    base64_stream_codec DUT (.*);

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // sink: random stalls, plus one long hold-off to back the codec up
    always @(posedge aclk) begin
        if (pressure_req && !pressure_taken) begin
            pressure_taken = 1'b1;
            hold_left      = PressureHold;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            sb.check_result(m_data);
        if (aresetn && ((s_valid && s_ready) || (m_valid && m_ready) || (psel && penable)))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial begin
        while (quiet_cycles < QuietLimit)
            @(posedge aclk);
        $display("CHECKS FAILED");
        $finish;
    end

    task automatic config_write(logic [2:0] addr, logic [31:0] value);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        if (addr == ModeAddr) begin
            sb.set_mode(value[0]);
            penable <= 1'b0;
            pwrite  <= 1'b0;
            @(posedge aclk);
            penable <= 1'b1;
            do @(posedge aclk); while (!pready);
            if (prdata !== {31'b0, value[0]}) begin
                $error("mode readback: expected %0h, got %0h", value[0], prdata);
                sb.errors++;
            end
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic send_item(logic [7:0] value, logic last);
        int gap;
        gap = 0;
        while (gap < MaxGap && $urandom_range(99) < idle_pct)
            gap++;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= '{in_byte: value, in_last: last};
        do @(posedge aclk); while (!s_ready);
        sb.take_input(s_data);
        items_sent++;
    endtask

    task automatic send_message(logic close);
        for (int i = 0; i < msg_bytes.size(); i++)
            send_item(msg_bytes[i], close && (i == msg_bytes.size() - 1));
    endtask

    task automatic load_text(string text);
        msg_bytes.delete();
        for (int i = 0; i < text.len(); i++)
            msg_bytes.push_back(text[i]);
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge aclk);
        repeat (SettleCycles) @(posedge aclk);
    endtask

    task automatic build_encode_message();
        msg_bytes.delete();
        repeat ($urandom_range(1, 8))
            msg_bytes.push_back(8'($urandom_range(255)));
    endtask

    // mostly well-formed quads; a quarter get a stray byte, a stray pad or a short tail
    task automatic build_decode_message();
        int pads;
        int pick;
        msg_bytes.delete();
        repeat (4 * $urandom_range(1, 3))
            msg_bytes.push_back(sb.alphabet[$urandom_range(63)]);
        pads = $urandom_range(2);
        for (int i = 0; i < pads; i++)
            msg_bytes[msg_bytes.size() - 1 - i] = PadChar;
        if ($urandom_range(99) < 25) begin
            pick = $urandom_range(msg_bytes.size() - 1);
            case ($urandom_range(2))
                0: msg_bytes[pick] = 8'($urandom_range(255));
                1: msg_bytes[pick] = PadChar;
                default: begin
                    repeat ($urandom_range(1, 3)) begin
                        if (msg_bytes.size() > 1)
                            void'(msg_bytes.pop_back());
                    end
                end
            endcase
        end
    endtask

    task automatic random_phase(int count);
        int start;
        start = items_sent;
        while (items_sent - start < count) begin
            if (sb.mode == MODE_ENCODE)
                build_encode_message();
            else
                build_decode_message();
            send_message(1'b1);
        end
        drain();
    endtask

    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // unmapped address must leave the codec in encode mode
        config_write(SpareAddr, 32'h1);
        msg_bytes = '{8'h00};
        send_message(1'b1);
        msg_bytes = '{8'hFF, 8'h80};
        send_message(1'b1);
        msg_bytes = '{8'h00, 8'hFF, 8'h5A};
        send_message(1'b1);
        msg_bytes = '{8'hA5};
        send_message(1'b0);
        drain();

        config_write(ModeAddr, {31'b0, MODE_DECODE});
        load_text("QQ");
        send_message(1'b0);
        drain();
        config_write(ModeAddr, {31'b0, MODE_DECODE});
        load_text("TQ==");
        send_message(1'b1);
        load_text("A");
        send_message(1'b1);
        msg_bytes = '{8'hFF};
        send_message(1'b1);
        load_text("a*==");
        send_message(1'b1);
        load_text("QQ=!");
        send_message(1'b1);
        drain();

        for (int p = 0; p < 4; p++) begin
            for (int k = 0; k < 2; k++) begin
                idle_pct  = idle_plan[p];
                stall_pct = stall_plan[p];
                config_write(ModeAddr, {31'b0, (k == 0) ? MODE_ENCODE : MODE_DECODE});
                random_phase(PhaseItems);
            end
        end

        // long sink hold-off with the source pushing flat out
        idle_pct  = 0;
        stall_pct = 0;
        config_write(ModeAddr, {31'b0, MODE_ENCODE});
        pressure_req = 1'b1;
        random_phase(24);

        if (sb.errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

>>> filelist.f
src/b64sc_pkg.sv
src/b64sc_front.sv
src/b64sc_queue.sv
src/b64sc_back.sv
src/base64_stream_codec.sv
verif/tb.sv
